FILE: hdl/rlm_pkg.sv
package rlm_pkg;

	localparam int COORD_W  = 7;
	localparam int CENTER_W = 9;
	localparam int RADIUS_W = 8;
	localparam int COLOR_W  = 16;
	localparam int DIFF_W   = CENTER_W;
	localparam int SQ_W     = 2 * DIFF_W;
	localparam int SUM_W    = SQ_W + 1;
	localparam int RSQ_W    = 2 * RADIUS_W;
	localparam int INDEX_W  = 3;
	localparam int WDATA_W  = CENTER_W;

	localparam int FRAME_WIDTH_DEF  = 128;
	localparam int FRAME_HEIGHT_DEF = 128;

	// Cycles from an accepted transaction to its result strobe.
	localparam int PIPE_LATENCY = 3;

	localparam logic signed [CENTER_W-1:0] CENTER_RESET = CENTER_W'(64);

	localparam logic [COLOR_W-1:0] QUARTER_MASK = 16'hF9E7;
	localparam logic [COLOR_W-1:0] HALF_MASK    = 16'hFBEF;

	typedef enum logic [INDEX_W-1:0] {
		REG_CENTER_X      = 3'd0,
		REG_CENTER_Y      = 3'd1,
		REG_INNER_RADIUS  = 3'd2,
		REG_MIDDLE_RADIUS = 3'd3,
		REG_OUTER_RADIUS  = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic signed [CENTER_W-1:0] center_x;
		logic signed [CENTER_W-1:0] center_y;
		logic [RADIUS_W-1:0]        outer;
		logic [RSQ_W-1:0]           inner_sq;
		logic [RSQ_W-1:0]           middle_sq;
		logic [RSQ_W-1:0]           outer_sq;
	} cfg_t;

	typedef struct packed {
		logic                in_frame;
		logic                box_out;
		logic [SQ_W-1:0]     dx_sq;
		logic [SQ_W-1:0]     dy_sq;
		logic [COLOR_W-1:0]  color;
	} dist_t;

endpackage

FILE: hdl/radial_light_mask.sv
// Pipeline: an accepted pixel passes three register stages, s1 and s2 in
// rlm_dist and s3 in rlm_band, before done strobes its result.
// Throughput: one pixel per clock; busy stays low, the pipeline never stalls
// and the receiver cannot hold results off.
// Reset: arst_n clears the pipeline valid flags and loads the centre at 64,64
// with all radii zero.
module radial_light_mask #(
	parameter int FRAME_WIDTH  = rlm_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = rlm_pkg::FRAME_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rlm_pkg::COORD_W-1:0]   pixel_x,
	input  logic [rlm_pkg::COORD_W-1:0]   pixel_y,
	input  logic [rlm_pkg::COLOR_W-1:0]   pixel_color,
	output logic                          done,
	output logic [rlm_pkg::COLOR_W-1:0]   masked_color,
	input  logic                          wr_en,
	input  logic [rlm_pkg::INDEX_W-1:0]   wr_index,
	input  logic [rlm_pkg::WDATA_W-1:0]   wr_data
);
	import rlm_pkg::*;

	cfg_t  cfg;
	logic  accept;
	logic  dist_valid;
	dist_t geom;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	rlm_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	rlm_dist #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_dist (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (accept),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.dist_valid  (dist_valid),
		.geom        (geom)
	);

	rlm_band u_band (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.dist_valid   (dist_valid),
		.geom         (geom),
		.done         (done),
		.masked_color (masked_color)
	);

endmodule

FILE: hdl/rlm_cfg_regs.sv
module rlm_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [rlm_pkg::INDEX_W-1:0]   wr_index,
	input  logic [rlm_pkg::WDATA_W-1:0]   wr_data,
	output rlm_pkg::cfg_t                 cfg
);
	import rlm_pkg::*;

	logic signed [CENTER_W-1:0] center_x_q;
	logic signed [CENTER_W-1:0] center_y_q;
	logic [RADIUS_W-1:0]        outer_q;
	logic [RSQ_W-1:0]           inner_sq_q;
	logic [RSQ_W-1:0]           middle_sq_q;
	logic [RSQ_W-1:0]           outer_sq_q;
	logic [RADIUS_W-1:0]        wr_radius;
	logic [RSQ_W-1:0]           wr_radius_sq;

	// Radii are kept squared so that the distance test need not square them per pixel.
	assign wr_radius    = wr_data[RADIUS_W-1:0];
	assign wr_radius_sq = RSQ_W'(wr_radius) * RSQ_W'(wr_radius);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q  <= CENTER_RESET;
			center_y_q  <= CENTER_RESET;
			outer_q     <= '0;
			inner_sq_q  <= '0;
			middle_sq_q <= '0;
			outer_sq_q  <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CENTER_X:      center_x_q  <= signed'(wr_data);
				REG_CENTER_Y:      center_y_q  <= signed'(wr_data);
				REG_INNER_RADIUS:  inner_sq_q  <= wr_radius_sq;
				REG_MIDDLE_RADIUS: middle_sq_q <= wr_radius_sq;
				REG_OUTER_RADIUS: begin
					outer_q    <= wr_radius;
					outer_sq_q <= wr_radius_sq;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.center_x  = center_x_q;
		cfg.center_y  = center_y_q;
		cfg.outer     = outer_q;
		cfg.inner_sq  = inner_sq_q;
		cfg.middle_sq = middle_sq_q;
		cfg.outer_sq  = outer_sq_q;
	end

endmodule

FILE: hdl/rlm_dist.sv
module rlm_dist #(
	parameter int FRAME_WIDTH  = rlm_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = rlm_pkg::FRAME_HEIGHT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rlm_pkg::cfg_t                 cfg,
	input  logic                          in_valid,
	input  logic [rlm_pkg::COORD_W-1:0]   pixel_x,
	input  logic [rlm_pkg::COORD_W-1:0]   pixel_y,
	input  logic [rlm_pkg::COLOR_W-1:0]   pixel_color,
	output logic                          dist_valid,
	output rlm_pkg::dist_t                geom
);
	import rlm_pkg::*;

	localparam int EXT_W = CENTER_W + 1;

	function automatic logic [DIFF_W-1:0] abs_diff(
		input logic [COORD_W-1:0]         p,
		input logic signed [CENTER_W-1:0] c
	);
		logic signed [EXT_W-1:0] d;
		begin
			d = signed'(EXT_W'(p)) - EXT_W'(c);
			abs_diff = d[EXT_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
		end
	endfunction

	logic                valid_s1;
	logic [DIFF_W-1:0]   dx_s1;
	logic [DIFF_W-1:0]   dy_s1;
	logic                in_frame_s1;
	logic [COLOR_W-1:0]  color_s1;
	logic                valid_s2;
	dist_t               dist_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1       <= abs_diff(pixel_x, cfg.center_x);
		dy_s1       <= abs_diff(pixel_y, cfg.center_y);
		in_frame_s1 <= (int'(pixel_x) < FRAME_WIDTH) && (int'(pixel_y) < FRAME_HEIGHT);
		color_s1    <= pixel_color;
	end

	always_ff @(posedge clk) begin
		dist_s2.in_frame <= in_frame_s1;
		dist_s2.box_out  <= (dx_s1 > DIFF_W'(cfg.outer)) || (dy_s1 > DIFF_W'(cfg.outer));
		dist_s2.dx_sq    <= SQ_W'(dx_s1) * SQ_W'(dx_s1);
		dist_s2.dy_sq    <= SQ_W'(dy_s1) * SQ_W'(dy_s1);
		dist_s2.color    <= color_s1;
	end

	assign dist_valid = valid_s2;
	assign geom       = dist_s2;

endmodule

FILE: hdl/rlm_band.sv
module rlm_band (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rlm_pkg::cfg_t                 cfg,
	input  logic                          dist_valid,
	input  rlm_pkg::dist_t                geom,
	output logic                          done,
	output logic [rlm_pkg::COLOR_W-1:0]   masked_color
);
	import rlm_pkg::*;

	logic [SUM_W-1:0]   d_sq;
	logic [COLOR_W-1:0] shaded;
	logic               done_s3;
	logic [COLOR_W-1:0] color_s3;

	assign d_sq = SUM_W'(geom.dx_sq) + SUM_W'(geom.dy_sq);

	// The band tests run in a fixed order, so radii given out of order simply lose effect.
	always_comb begin
		if (!geom.in_frame) begin
			shaded = geom.color;
		end else if (geom.box_out || (d_sq > SUM_W'(cfg.outer_sq))) begin
			shaded = '0;
		end else if (d_sq > SUM_W'(cfg.middle_sq)) begin
			shaded = (geom.color >> 2) & QUARTER_MASK;
		end else if (d_sq > SUM_W'(cfg.inner_sq)) begin
			shaded = (geom.color >> 1) & HALF_MASK;
		end else begin
			shaded = geom.color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s3 <= 1'b0;
		end else begin
			done_s3 <= dist_valid;
		end
	end

	always_ff @(posedge clk) begin
		color_s3 <= shaded;
	end

	assign done         = done_s3;
	assign masked_color = color_s3;

endmodule

FILE: hdl/rlm_checker.sv
module rlm_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [rlm_pkg::COLOR_W-1:0]   pixel_color,
	input  logic                          done,
	input  logic [rlm_pkg::COLOR_W-1:0]   masked_color
);
	import rlm_pkg::*;

	logic accept;

	assign accept = start && !busy;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised on a pipeline that never stalls");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##PIPE_LATENCY done)
		else $error("accepted transaction produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, PIPE_LATENCY))
		else $error("result strobe without a matching transaction");

	// Every band only dims the colour, so the result never exceeds the input value.
	a_never_brighter: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (masked_color <= $past(pixel_color, PIPE_LATENCY)))
		else $error("masked colour brighter than the input colour");

endmodule

bind radial_light_mask rlm_checker u_rlm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.pixel_color  (pixel_color),
	.done         (done),
	.masked_color (masked_color)
);

FILE: bench/tb_radial_light_mask.sv
`timescale 1ns / 1ps

module tb_radial_light_mask;
	import rlm_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int REPORT_LIMIT    = 10;
	localparam int NUM_REGS        = int'(REG_OUTER_RADIUS) + 1;
	localparam int CENTER_MIN      = -128;
	localparam int CENTER_MAX      = 255;
	localparam int RADIUS_MAX      = 255;
	localparam int COORD_MAX       = (1 << COORD_W) - 1;
	localparam int RANDOM_PHASES   = 12;
	localparam int ITEMS_PER_PHASE = 100;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COLOR_W-1:0] color;
	} pixel_t;

	typedef struct packed {
		pixel_t             pix;
		logic [COLOR_W-1:0] shade;
	} shade_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               start        = 1'b0;
	logic               busy;
	logic [COORD_W-1:0] pixel_x      = '0;
	logic [COORD_W-1:0] pixel_y      = '0;
	logic [COLOR_W-1:0] pixel_color  = '0;
	logic               done;
	logic [COLOR_W-1:0] masked_color;
	logic               wr_en        = 1'b0;
	logic [INDEX_W-1:0] wr_index     = '0;
	logic [WDATA_W-1:0] wr_data      = '0;

	// Our own copy of the light settings, kept in step with every register write.
	logic signed [CENTER_W-1:0] light_cx = CENTER_RESET;
	logic signed [CENTER_W-1:0] light_cy = CENTER_RESET;
	logic [RADIUS_W-1:0]        r_inner  = '0;
	logic [RADIUS_W-1:0]        r_middle = '0;
	logic [RADIUS_W-1:0]        r_outer  = '0;

	pixel_t pixel_queue[$];
	shade_t shade_queue[$];
	int     mismatches = 0;
	int     cycles     = 0;
	int     gap_left   = 0;
	int     burst_left = 0;

	radial_light_mask u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_color  (pixel_color),
		.done         (done),
		.masked_color (masked_color),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [COLOR_W-1:0] shade_pixel(input pixel_t p);
		int dx, dy, d2;
		if (int'(p.x) >= FRAME_WIDTH_DEF || int'(p.y) >= FRAME_HEIGHT_DEF)
			return p.color;
		dx = int'(p.x) - int'(light_cx);
		dy = int'(p.y) - int'(light_cy);
		if (dx < 0)
			dx = -dx;
		if (dy < 0)
			dy = -dy;
		d2 = dx * dx + dy * dy;
		if (dx > int'(r_outer) || dy > int'(r_outer) || d2 > int'(r_outer) * int'(r_outer))
			return '0;
		if (d2 > int'(r_middle) * int'(r_middle))
			return (p.color >> 2) & QUARTER_MASK;
		if (d2 > int'(r_inner) * int'(r_inner))
			return (p.color >> 1) & HALF_MASK;
		return p.color;
	endfunction

	// Coordinate scattered around a centre, reaching just past the outer radius.
	function automatic logic [COORD_W-1:0] near_coord(input int centre);
		int span, v;
		span = int'(r_outer) + 2;
		v = centre + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0)
			v = 0;
		if (v > COORD_MAX)
			v = COORD_MAX;
		return COORD_W'(v);
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Driver: the transaction on the ports is taken at this edge if start is high
	// and busy low; the next one is then presented unless a gap is running or none is queued.
	always @(posedge clk) begin
		pixel_t next_pix;
		if (arst_n) begin
			if (start && !busy)
				shade_queue.push_back('{pix: '{x: pixel_x, y: pixel_y, color: pixel_color},
					shade: shade_pixel('{x: pixel_x, y: pixel_y, color: pixel_color})});
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pixel_queue.size() > 0) begin
					next_pix = pixel_queue.pop_front();
					pixel_x <= next_pix.x;
					pixel_y <= next_pix.y;
					pixel_color <= next_pix.color;
					start <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: done and the colour are stable by the falling edge of their cycle.
	always @(negedge clk) begin
		shade_t want;
		if (arst_n && done) begin
			if (shade_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result: masked_color=%h", masked_color);
			end else begin
				want = shade_queue.pop_front();
				if (masked_color !== want.shade) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("pixel (%0d,%0d) colour %h: expected %h, got %h",
							want.pix.x, want.pix.y, want.pix.color, want.shade, masked_color);
				end
			end
		end
	end

	task automatic write_reg(input logic [INDEX_W-1:0] idx, input int value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= WDATA_W'(value);
		case (idx)
			REG_CENTER_X:      light_cx = CENTER_W'(value);
			REG_CENTER_Y:      light_cy = CENTER_W'(value);
			REG_INNER_RADIUS:  r_inner = RADIUS_W'(value);
			REG_MIDDLE_RADIUS: r_middle = RADIUS_W'(value);
			REG_OUTER_RADIUS:  r_outer = RADIUS_W'(value);
			default: ;
		endcase
	endtask

	// Writes all five registers, starting at a random one, with stray top bits on
	// the radii and now and then a write to an unused index.
	task automatic configure(input int cx, input int cy, input int inner, input int middle,
		input int outer);
		int         vals[NUM_REGS];
		int         rot, value;
		reg_index_t idx;
		vals = '{cx, cy, inner, middle, outer};
		rot = $urandom_range(0, NUM_REGS - 1);
		for (int k = 0; k < NUM_REGS; k++) begin
			idx = reg_index_t'((rot + k) % NUM_REGS);
			value = vals[int'(idx)];
			if (idx >= REG_INNER_RADIUS)
				value |= $urandom_range(0, 1) << RADIUS_W;
			write_reg(idx, value);
		end
		if ($urandom_range(0, 3) == 0)
			write_reg(INDEX_W'($urandom_range(NUM_REGS, (1 << INDEX_W) - 1)),
				$urandom_range(0, (1 << WDATA_W) - 1));
		@(posedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_pixel(input int x, input int y, input logic [COLOR_W-1:0] color);
		pixel_queue.push_back('{x: COORD_W'(x), y: COORD_W'(y), color: color});
	endtask

	// Returns once every queued transaction has been taken and its result checked.
	task automatic drain();
		do
			@(negedge clk);
		while (pixel_queue.size() != 0 || start || shade_queue.size() != 0);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int     cx, cy, inner, middle, outer, span;
		pixel_t p;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: only the centre itself keeps its colour.
		queue_pixel(64, 64, 16'hFFFF);
		queue_pixel(65, 64, 16'hFFFF);
		queue_pixel(0, 0, 16'h1234);
		drain();

		// Band edges on both sides of each radius, and a corner of the box.
		configure(64, 64, 10, 20, 30);
		queue_pixel(74, 64, 16'hFFFF);
		queue_pixel(75, 64, 16'hFFFF);
		queue_pixel(84, 64, 16'hFFFF);
		queue_pixel(85, 64, 16'hFFFF);
		queue_pixel(94, 64, 16'hFFFF);
		queue_pixel(95, 64, 16'hFFFF);
		queue_pixel(64, 34, 16'hA5A5);
		queue_pixel(85, 85, 16'hFFFF);
		queue_pixel(86, 86, 16'hFFFF);
		queue_pixel(94, 94, 16'hFFFF);
		drain();

		// Centre at a corner of its test range, middle and outer radii at their widest.
		configure(CENTER_MIN, CENTER_MAX, 0, RADIUS_MAX, RADIUS_MAX);
		queue_pixel(COORD_MAX, 0, 16'hFFFF);
		queue_pixel(0, COORD_MAX, 16'hFFFF);
		queue_pixel(COORD_MAX, COORD_MAX, 16'h5555);
		drain();

		// Middle radius beyond the outer one has no effect.
		configure(COORD_MAX, 0, 200, RADIUS_MAX, 150);
		queue_pixel(COORD_MAX, 0, 16'hFFFF);
		queue_pixel(0, 0, 16'hFFFF);
		queue_pixel(27, COORD_MAX, 16'hFFFF);
		queue_pixel(0, COORD_MAX, 16'hFFFF);
		drain();

		// Inner radius beyond the middle one, after writes to unused indices.
		for (int i = NUM_REGS; i < (1 << INDEX_W); i++)
			write_reg(INDEX_W'(i), (1 << WDATA_W) - 1);
		configure(0, 0, 50, 10, 60);
		queue_pixel(0, 0, 16'hFFFF);
		queue_pixel(5, 0, 16'hFFFF);
		queue_pixel(20, 0, 16'hFFFF);
		queue_pixel(60, 0, 16'hFFFF);
		queue_pixel(61, 0, 16'hFFFF);
		drain();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase == 0) begin
				configure(CENTER_MIN, CENTER_MIN, RADIUS_MAX, RADIUS_MAX, RADIUS_MAX);
			end else if (phase == 1) begin
				configure(CENTER_MAX, CENTER_MAX, 0, 0, 0);
			end else if (phase == 2) begin
				configure(64, 64, RADIUS_MAX, RADIUS_MAX, RADIUS_MAX);
			end else begin
				if ($urandom_range(0, 3) != 0) begin
					cx = $urandom_range(0, COORD_MAX);
					cy = $urandom_range(0, COORD_MAX);
				end else begin
					cx = int'($urandom_range(0, CENTER_MAX - CENTER_MIN)) + CENTER_MIN;
					cy = int'($urandom_range(0, CENTER_MAX - CENTER_MIN)) + CENTER_MIN;
				end
				span = $urandom_range(0, 1) ? $urandom_range(0, 40) : RADIUS_MAX;
				if ($urandom_range(0, 2) != 0) begin
					inner = $urandom_range(0, span);
					middle = $urandom_range(inner, span);
					outer = $urandom_range(middle, span);
				end else begin
					inner = $urandom_range(0, span);
					middle = $urandom_range(0, span);
					outer = $urandom_range(0, span);
				end
				configure(cx, cy, inner, middle, outer);
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 1)) begin
					p.x = near_coord(int'(light_cx));
					p.y = near_coord(int'(light_cy));
				end else begin
					p.x = COORD_W'($urandom_range(0, COORD_MAX));
					p.y = COORD_W'($urandom_range(0, COORD_MAX));
				end
				p.color = COLOR_W'($urandom_range(0, (1 << COLOR_W) - 1));
				pixel_queue.push_back(p);
			end
			drain();
		end

		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
